// ===== sv/tfet_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch finger event tracker package
// Shared types and constants for the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tfet_pkg;

	// Event codes carried on event_res.
	localparam logic [1:0] EV_DOWN = 2'd1;
	localparam logic [1:0] EV_MOVE = 2'd2;
	localparam logic [1:0] EV_UP   = 2'd3;

	// Input operation codes.
	localparam logic OP_FINGER = 1'b0;
	localparam logic OP_END    = 1'b1;

	// Fixed-point format of the scale factors.
	localparam int Q_SHIFT = 10;

	// Configuration register indexes.
	localparam logic REG_SCALE_X = 1'b0;
	localparam logic REG_SCALE_Y = 1'b1;

	// Front end states.
	typedef enum logic {
		FE_IDLE,
		FE_WALK
	} fe_state_t;

	// One event waiting to be scaled and delivered.
	typedef struct packed {
		logic [1:0]  ev;
		logic [3:0]  fnum;
		logic [15:0] raw_x;
		logic [15:0] raw_y;
		logic        last;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/tfet_queue.sv =====
// ----------------------------------------------------------------------------
// Touch finger event tracker command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfet_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tfet_pkg::cmd_t push_data,
	output logic               can_push,
	input  wire logic          pop,
	output logic               head_valid,
	output tfet_pkg::cmd_t     head_data
);

	tfet_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	// Status toward both sides.
	assign can_push   = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/tfet_front.sv =====
// ----------------------------------------------------------------------------
// Touch finger event tracker front end
// Accepts items, tracks down and seen fingers, and queues one event per in-range
// finger record or one up event per lifted finger of an end-of-report item.
// ----------------------------------------------------------------------------
`default_nettype none

module tfet_front #(
	parameter int FINGER_SLOTS = 5
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire logic           op,
	input  wire logic [7:0]     finger_id,
	input  wire logic [15:0]    raw_x,
	input  wire logic [15:0]    raw_y,
	input  wire logic           can_push,
	output logic                push,
	output tfet_pkg::cmd_t      push_data
);

	localparam int IW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

	tfet_pkg::fe_state_t     state_q;
	tfet_pkg::fe_state_t     state_d;
	logic [FINGER_SLOTS-1:0] down_q;
	logic [FINGER_SLOTS-1:0] seen_q;
	logic [FINGER_SLOTS-1:0] walk_q;
	logic [FINGER_SLOTS-1:0] down_d;
	logic [FINGER_SLOTS-1:0] seen_d;
	logic [FINGER_SLOTS-1:0] walk_d;
	logic [15:0]             sx_q [FINGER_SLOTS];
	logic [15:0]             sy_q [FINGER_SLOTS];

	logic                    accept;
	logic                    id_ok;
	logic [IW-1:0]           rec_idx;
	logic [FINGER_SLOTS-1:0] rec_bit;
	logic [FINGER_SLOTS-1:0] lift;
	logic [IW-1:0]           walk_idx;
	logic [FINGER_SLOTS-1:0] walk_bit;
	logic                    walk_last;
	logic                    store_en;

	// Decode of the incoming finger record.
	assign accept  = item_valid && !item_stall;
	assign id_ok   = (finger_id < 8'(FINGER_SLOTS));
	assign rec_idx = finger_id[IW-1:0];
	assign rec_bit = FINGER_SLOTS'(1) << rec_idx;
	assign lift    = down_q & ~seen_q;

	// Lowest finger still to be lifted during a walk.
	always_comb begin
		walk_idx = '0;
		for (int i = FINGER_SLOTS - 1; i >= 0; i--) begin
			if (walk_q[i]) begin
				walk_idx = IW'(i);
			end
		end
	end

	assign walk_bit  = FINGER_SLOTS'(1) << walk_idx;
	assign walk_last = ((walk_q & ~walk_bit) == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tfet_pkg::FE_IDLE: begin
				if (accept && op == tfet_pkg::OP_END && lift != '0) begin
					state_d = tfet_pkg::FE_WALK;
				end
			end
			tfet_pkg::FE_WALK: begin
				if (can_push && walk_last) begin
					state_d = tfet_pkg::FE_IDLE;
				end
			end
			default: state_d = tfet_pkg::FE_IDLE;
		endcase
	end

	// Outputs and mask updates.
	always_comb begin
		item_stall = 1'b1;
		push       = 1'b0;
		push_data  = '0;
		down_d     = down_q;
		seen_d     = seen_q;
		walk_d     = walk_q;
		store_en   = 1'b0;
		case (state_q)
			tfet_pkg::FE_IDLE: begin
				item_stall = !can_push;
				if (accept && op == tfet_pkg::OP_FINGER && id_ok) begin
					push           = 1'b1;
					push_data.ev   = ((down_q & rec_bit) != '0) ? tfet_pkg::EV_MOVE
						: tfet_pkg::EV_DOWN;
					push_data.fnum = finger_id[3:0] + 4'd1;
					push_data.raw_x = raw_x;
					push_data.raw_y = raw_y;
					push_data.last = 1'b1;
					down_d         = down_q | rec_bit;
					seen_d         = seen_q | rec_bit;
					store_en       = 1'b1;
				end else if (accept && op == tfet_pkg::OP_END) begin
					// Lifted fingers leave the down set now; the walk reports them.
					seen_d = '0;
					down_d = down_q & ~lift;
					walk_d = lift;
				end
			end
			tfet_pkg::FE_WALK: begin
				if (can_push) begin
					push            = 1'b1;
					push_data.ev    = tfet_pkg::EV_UP;
					push_data.fnum  = 4'(walk_idx) + 4'd1;
					push_data.raw_x = sx_q[walk_idx];
					push_data.raw_y = sy_q[walk_idx];
					push_data.last  = walk_last;
					walk_d          = walk_q & ~walk_bit;
				end
			end
			default: item_stall = 1'b1;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfet_pkg::FE_IDLE;
			down_q  <= '0;
			seen_q  <= '0;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			down_q  <= down_d;
			seen_q  <= seen_d;
			walk_q  <= walk_d;
		end
	end

	// Stored raw coordinates of each finger.
	always_ff @(posedge clk) begin
		if (store_en) begin
			sx_q[rec_idx] <= raw_x;
			sy_q[rec_idx] <= raw_y;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tfet_back.sv =====
// ----------------------------------------------------------------------------
// Touch finger event tracker back end
// Scales queued events by the Q10 factors, saturates them and holds each
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tfet_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    scale_x,
	input  wire logic [15:0]    scale_y,
	input  wire logic           head_valid,
	input  wire tfet_pkg::cmd_t head_data,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output logic [1:0]          event_res,
	output logic [3:0]          finger_number,
	output logic [15:0]         x,
	output logic [15:0]         y,
	output logic                last
);

	logic           valid_s1;
	tfet_pkg::cmd_t cmd_s1;
	logic [31:0]    prod_x_s1;
	logic [31:0]    prod_y_s1;
	logic           valid_s2;
	logic           adv2;
	logic           load1;
	logic [21:0]    shx;
	logic [21:0]    shy;

	// Stage advance.
	assign adv2  = !valid_s2 || !result_stall;
	assign load1 = !valid_s1 || adv2;
	assign pop   = head_valid && load1;

	// Q10 shift of the products.
	assign shx = prod_x_s1[31:tfet_pkg::Q_SHIFT];
	assign shy = prod_y_s1[31:tfet_pkg::Q_SHIFT];

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load1) begin
				valid_s1 <= head_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage one: multiply raw coordinates by the scale factors.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1    <= head_data;
			prod_x_s1 <= 32'(head_data.raw_x) * 32'(scale_x);
			prod_y_s1 <= 32'(head_data.raw_y) * 32'(scale_y);
		end
	end

	// Stage two: saturate to 16 bits into the output register.
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			event_res     <= cmd_s1.ev;
			finger_number <= cmd_s1.fnum;
			x             <= (shx[21:16] != '0) ? 16'hFFFF : shx[15:0];
			y             <= (shy[21:16] != '0) ? 16'hFFFF : shy[15:0];
			last          <= cmd_s1.last;
		end
	end

	assign result_valid = valid_s2;

endmodule

`default_nettype wire

// ===== sv/touch_finger_event_tracker.sv =====
// ----------------------------------------------------------------------------
// Touch finger event tracker
// Turns touch controller reports into per-finger down, move and up events.
// ----------------------------------------------------------------------------
// A finger record is taken and yields one down or move event; a record whose
// id is at or above FINGER_SLOTS is taken and dropped. After an end-of-report
// item is taken, the front end walks the lifted fingers in increasing id
// order, one up event a cycle while the queue has room, holding off new items
// until the walk ends. A two-entry queue decouples the front end from the back
// end, which multiplies and saturates in two stages; an event passes through
// the queue, the product register and the output register, and results flow
// at one per cycle while result_stall is low. Scale registers sit at byte
// addresses 0 (scale_x) and 4 (scale_y), reset to 1024 (unity in Q10).
// ----------------------------------------------------------------------------
`default_nettype none

module touch_finger_event_tracker #(
	parameter int FINGER_SLOTS = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input items.
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        op,
	input  wire logic [7:0]  finger_id,
	input  wire logic [15:0] raw_x,
	input  wire logic [15:0] raw_y,
	// Result items.
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       event_res,
	output logic [3:0]       finger_number,
	output logic [15:0]      x,
	output logic [15:0]      y,
	output logic             last
);

	logic [15:0]    scale_x_q;
	logic [15:0]    scale_y_q;
	logic           cfg_wr;
	logic           can_push;
	logic           push;
	tfet_pkg::cmd_t push_data;
	logic           pop;
	logic           head_valid;
	tfet_pkg::cmd_t head_data;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= 16'd1024;
			scale_y_q <= 16'd1024;
		end else if (cfg_wr) begin
			case (paddr[2])
				tfet_pkg::REG_SCALE_X: scale_x_q <= pwdata[15:0];
				tfet_pkg::REG_SCALE_Y: scale_y_q <= pwdata[15:0];
				default:               scale_x_q <= scale_x_q;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[2])
			tfet_pkg::REG_SCALE_X: prdata = {16'd0, scale_x_q};
			tfet_pkg::REG_SCALE_Y: prdata = {16'd0, scale_y_q};
			default:               prdata = '0;
		endcase
	end

	// Front end: finger tracking.
	tfet_front #(
		.FINGER_SLOTS(FINGER_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.finger_id  (finger_id),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.can_push   (can_push),
		.push       (push),
		.push_data  (push_data)
	);

	// Event queue.
	tfet_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.can_push   (can_push),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Back end: scaling and output register.
	tfet_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.scale_x       (scale_x_q),
		.scale_y       (scale_y_q),
		.head_valid    (head_valid),
		.head_data     (head_data),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.event_res     (event_res),
		.finger_number (finger_number),
		.x             (x),
		.y             (y),
		.last          (last)
	);

endmodule

`default_nettype wire

// ===== tb/tfet_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch finger event tracker checker
// Watches the configuration port and both item channels, predicts the down,
// move and up events of every accepted item, and compares them in order.
// ----------------------------------------------------------------------------

module tfet_event_checker #(
	parameter int FINGER_SLOTS = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        item_valid,
	input  wire logic        item_stall,
	input  wire logic        op,
	input  wire logic [7:0]  finger_id,
	input  wire logic [15:0] raw_x,
	input  wire logic [15:0] raw_y,
	input  wire logic        result_valid,
	input  wire logic        result_stall,
	input  wire logic [1:0]  event_res,
	input  wire logic [3:0]  finger_number,
	input  wire logic [15:0] x,
	input  wire logic [15:0] y,
	input  wire logic        last,
	output int               mismatch_count,
	output int               events_pending,
	output int               events_checked
);

	localparam logic [15:0] SCALE_UNITY = 16'd1 << tfet_pkg::Q_SHIFT;
	localparam int IW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

	// One touch event as it should leave the block.
	typedef struct packed {
		logic [1:0]  ev;
		logic [3:0]  fnum;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} touch_event_t;

	touch_event_t expected_events[$];

	logic [15:0]             scale_x_q;
	logic [15:0]             scale_y_q;
	logic [FINGER_SLOTS-1:0] down_q;
	logic [FINGER_SLOTS-1:0] seen_q;
	logic [15:0]             pos_x[FINGER_SLOTS];
	logic [15:0]             pos_y[FINGER_SLOTS];
	int                      fails;
	int                      checked;

	// Q10 scaling of a raw coordinate, clipped to the 16-bit screen range.
	function automatic logic [15:0] scale_coord(input logic [15:0] raw,
		input logic [15:0] factor);
		logic [31:0] prod;
		prod = ({16'd0, raw} * {16'd0, factor}) >> tfet_pkg::Q_SHIFT;
		return (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
	endfunction

	// Updates the finger state for one item and queues the events it causes.
	task automatic predict_events(input logic item_op, input logic [7:0] id,
		input logic [15:0] px, input logic [15:0] py);
		touch_event_t ev;
		int lifted;
		logic [IW-1:0] slot;
		lifted = 0;
		slot = id[IW-1:0];
		if (item_op == tfet_pkg::OP_FINGER) begin
			// Records for ids beyond the tracked fingers are dropped.
			if (id < FINGER_SLOTS) begin
				ev.ev = down_q[slot] ? tfet_pkg::EV_MOVE : tfet_pkg::EV_DOWN;
				ev.fnum = id[3:0] + 4'd1;
				ev.x = scale_coord(px, scale_x_q);
				ev.y = scale_coord(py, scale_y_q);
				ev.last = 1'b1;
				expected_events.push_back(ev);
				pos_x[slot] = px;
				pos_y[slot] = py;
				down_q[slot] = 1'b1;
				seen_q[slot] = 1'b1;
			end
		end else begin
			// Every finger that is down but missing from the report is lifted.
			for (int f = 0; f < FINGER_SLOTS; f++) begin
				if (down_q[f] && !seen_q[f]) begin
					ev.ev = tfet_pkg::EV_UP;
					ev.fnum = 4'(f + 1);
					ev.x = scale_coord(pos_x[f], scale_x_q);
					ev.y = scale_coord(pos_y[f], scale_y_q);
					ev.last = 1'b0;
					expected_events.push_back(ev);
					down_q[f] = 1'b0;
					lifted++;
				end
			end
			if (lifted > 0) begin
				ev = expected_events.pop_back();
				ev.last = 1'b1;
				expected_events.push_back(ev);
			end
			seen_q = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_val,
		input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s differs, expected %0d, actual %0d", $time, name,
				exp_val, act_val);
			fails++;
		end
	endtask

	// Tracks register writes, predicts on accepted items, checks results.
	always @(posedge clk or negedge arst_n) begin
		touch_event_t exp_ev;
		if (!arst_n) begin
			scale_x_q = SCALE_UNITY;
			scale_y_q = SCALE_UNITY;
			down_q = '0;
			seen_q = '0;
			expected_events.delete();
			fails = 0;
			checked = 0;
			mismatch_count <= 0;
			events_pending <= 0;
			events_checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == tfet_pkg::REG_SCALE_X)
					scale_x_q = pwdata[15:0];
				else
					scale_y_q = pwdata[15:0];
			end
			if (item_valid && !item_stall)
				predict_events(op, finger_id, raw_x, raw_y);
			if (result_valid && !result_stall) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected result, event %0d finger %0d x %0d y %0d",
						$time, event_res, finger_number, x, y);
					fails++;
				end else begin
					exp_ev = expected_events.pop_front();
					check_field("event_res", 16'(exp_ev.ev), 16'(event_res));
					check_field("finger_number", 16'(exp_ev.fnum), 16'(finger_number));
					check_field("x", exp_ev.x, x);
					check_field("y", exp_ev.y, y);
					check_field("last", 16'(exp_ev.last), 16'(last));
					checked++;
				end
			end
			mismatch_count <= fails;
			events_pending <= expected_events.size();
			events_checked <= checked;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch finger event tracker testbench
// Drives directed and random touch reports under several scale settings,
// with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------

module testbench;

	localparam int FINGERS      = 5;
	localparam int RANDOM_ITEMS = 460;
	localparam int PHASES       = 5;
	localparam int CALM_ITEMS   = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 300000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	logic        op;
	logic [7:0]  finger_id;
	logic [15:0] raw_x;
	logic [15:0] raw_y;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  event_res;
	logic [3:0]  finger_number;
	logic [15:0] x;
	logic [15:0] y;
	logic        last;

	int mismatch_count;
	int events_pending;
	int events_checked;
	int items_sent;
	int hold_requested;
	bit quiet;

	touch_finger_event_tracker #(
		.FINGER_SLOTS(FINGERS)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .op(op),
		.finger_id(finger_id), .raw_x(raw_x), .raw_y(raw_y),
		.result_valid(result_valid), .result_stall(result_stall),
		.event_res(event_res), .finger_number(finger_number), .x(x), .y(y),
		.last(last)
	);

	tfet_event_checker #(
		.FINGER_SLOTS(FINGERS)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .op(op),
		.finger_id(finger_id), .raw_x(raw_x), .raw_y(raw_y),
		.result_valid(result_valid), .result_stall(result_stall),
		.event_res(event_res), .finger_number(finger_number), .x(x), .y(y),
		.last(last),
		.mismatch_count(mismatch_count), .events_pending(events_pending),
		.events_checked(events_checked)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Global timeout.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d events outstanding",
			cycles, events_pending);
		$display("Mismatches found");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		int hold_served;
		hold_served = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requested) begin
				hold_served++;
				result_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				result_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Coordinates lean toward the edges of the panel and small values.
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Offers one item, after an optional idle burst, and waits until it is taken.
	task automatic send_item(input logic item_op, input logic [7:0] id,
		input logic [15:0] px, input logic [15:0] py);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= item_op;
		finger_id <= id;
		raw_x <= px;
		raw_y <= py;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// One controller report: a few finger records, mostly closed by an end item.
	task automatic send_report();
		int count;
		logic [7:0] id;
		count = $urandom_range(0, FINGERS);
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				id = 8'($urandom_range(FINGERS, 255));
			else
				id = 8'($urandom_range(0, FINGERS - 1));
			send_item(tfet_pkg::OP_FINGER, id, pick_coord(), pick_coord());
		end
		if ($urandom_range(0, 19) != 0)
			send_item(tfet_pkg::OP_END, 8'($urandom_range(0, 255)), pick_coord(),
				pick_coord());
	endtask

	task automatic apb_write(input logic reg_idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every event has come out and the block is quiet.
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (events_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Main stimulus and verdict.
	initial begin
		int target;
		logic [15:0] sx;
		logic [15:0] sy;
		items_sent = 0;
		hold_requested = 0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		op <= tfet_pkg::OP_FINGER;
		finger_id <= '0;
		raw_x <= '0;
		raw_y <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: end of report with nothing down lifts nothing.
		send_item(tfet_pkg::OP_END, 8'd0, 16'd0, 16'd0);
		// First and last finger go down at the panel extremes, then one moves.
		send_item(tfet_pkg::OP_FINGER, 8'd0, 16'h0000, 16'h0000);
		send_item(tfet_pkg::OP_FINGER, 8'(FINGERS - 1), 16'hFFFF, 16'hFFFF);
		send_item(tfet_pkg::OP_FINGER, 8'd0, 16'd12345, 16'd54321);
		// Ids outside the tracked range are dropped.
		send_item(tfet_pkg::OP_FINGER, 8'(FINGERS), 16'd100, 16'd200);
		send_item(tfet_pkg::OP_FINGER, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_item(tfet_pkg::OP_FINGER, 8'h80, 16'h5555, 16'hAAAA);
		// Both fingers were seen, so the end item lifts nothing.
		send_item(tfet_pkg::OP_END, 8'hFF, 16'hFFFF, 16'hFFFF);
		// The last finger goes missing and is lifted with its stored position.
		send_item(tfet_pkg::OP_FINGER, 8'd0, 16'd40000, 16'd30000);
		send_item(tfet_pkg::OP_END, 8'd0, 16'd0, 16'd0);
		// Three new fingers while finger zero vanishes, then all three vanish.
		for (int f = 1; f < 4; f++)
			send_item(tfet_pkg::OP_FINGER, 8'(f), 16'(f * 1000), 16'(f * 2000));
		send_item(tfet_pkg::OP_END, 8'd0, 16'd0, 16'd0);
		send_item(tfet_pkg::OP_END, 8'd0, 16'd0, 16'd0);
		// Every finger down, then all lifted by one end item.
		for (int f = 0; f < FINGERS; f++)
			send_item(tfet_pkg::OP_FINGER, 8'(f), pick_coord(), pick_coord());
		send_item(tfet_pkg::OP_END, 8'd0, 16'd0, 16'd0);
		send_item(tfet_pkg::OP_END, 8'd0, 16'd0, 16'd0);

		// Random reports under several scale settings.
		items_sent = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					sx = 16'hFFFF;
					sy = 16'h0000;
				end
				1: begin
					sx = 16'h0000;
					sy = 16'hFFFF;
				end
				2: begin
					sx = 16'($urandom_range(0, 4096));
					sy = 16'($urandom_range(0, 4096));
				end
				3: begin
					sx = 16'($urandom_range(0, 16'hFFFF));
					sy = 16'($urandom_range(0, 16'hFFFF));
				end
				default: begin
					sx = 16'd1 << tfet_pkg::Q_SHIFT;
					sy = 16'd1 << tfet_pkg::Q_SHIFT;
				end
			endcase
			wait_drained();
			apb_write(tfet_pkg::REG_SCALE_X, sx);
			apb_write(tfet_pkg::REG_SCALE_Y, sy);
			// Hold results back while reports keep coming, to back up the block.
			if (phase == 1)
				hold_requested++;
			target = RANDOM_ITEMS * (phase + 1) / PHASES;
			while (items_sent < target) begin
				quiet = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
				send_report();
			end
		end

		wait_drained();
		$display("Checked %0d events from %0d random items plus a directed set,",
			events_checked, items_sent);
		$display("over %0d scale settings including both extremes.", PHASES + 1);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== touch_finger_event_tracker.f =====
sv/tfet_pkg.sv
sv/tfet_queue.sv
sv/tfet_front.sv
sv/tfet_back.sv
sv/touch_finger_event_tracker.sv
tb/tfet_event_checker.sv
tb/testbench.sv
